// File: rtl/core/trps_pkg.sv
// Shared types and Q2.16 constants for the telemetry risk peak score block.
// No dependencies; imported by every module under rtl/core.
`default_nettype none

package trps_pkg;

	localparam logic [17:0] ONE_Q16   = 18'd65536;
	localparam logic [17:0] TWO_Q16   = 18'd131072;
	localparam logic [17:0] THREE_Q16 = 18'd196608;

	// Registered copy of one input transaction
	typedef struct packed {
		logic [15:0] power;
		logic [12:0] temp;    // two's complement, 1/16 degree
		logic [16:0] err;
		logic [16:0] expo;
		logic        last;
	} sample_t;

	// Normalized values, unsigned Q2.16
	typedef struct packed {
		logic [17:0] p;
		logic [17:0] t;
		logic [17:0] e;
		logic [17:0] x;
		logic        last;
	} norm_t;

	// Per-stage load enables from the pipeline control in the top level
	typedef struct packed {
		logic en_s2;
		logic en_s3;
		logic en_s4;
	} ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/trps_norm.sv
// Normalization stage: piecewise-linear scaling of the four telemetry values
// against their ceilings, clamped, registered into stage 2. Uses trps_pkg.
`default_nettype none

module trps_norm (
	input  wire                     clk,
	input  trps_pkg::sample_t       smp_s1,
	input  trps_pkg::ctl_t          ctl,
	output trps_pkg::norm_t         norm_s2
);
	import trps_pkg::*;

	// floor(m * 16384 / 125) = (m * P_RECIP) >> 17, exact for m < 1000
	localparam logic [24:0] P_RECIP = 25'd17179870;
	// floor(m * 2048 / 65) = (m * T_RECIP) >> 18, exact for m < 7900
	localparam logic [22:0] T_RECIP = 23'd8259553;
	// floor(m / 9) = (m * X_RECIP) >> 24, exact for m < 2^21
	localparam logic [20:0] X_RECIP = 21'd1864136;

	logic [9:0]  p_m;
	logic [34:0] p_prod;
	logic [17:0] p_n;

	logic        t_pos;
	logic [11:0] t_u;
	logic [12:0] t_m;
	logic [35:0] t_prod;
	logic [17:0] t_n;

	logic [16:0] e_sat;
	logic [19:0] e_v;
	logic [17:0] e_n;

	logic [16:0] x_sat;
	logic [20:0] x_m;
	logic [41:0] x_prod;
	logic [17:0] x_n;

	norm_t       norm_d;

	// power: below 250 mW the slope is 1/250, above it 1/500 from 1.0
	always_comb begin
		if (smp_s1.power <= 16'd250) begin
			p_m = {smp_s1.power[8:0], 1'b0};
		end else begin
			p_m = smp_s1.power[9:0] + 10'd250;
		end
		p_prod = 35'(p_m) * 35'(P_RECIP);
		// 750 mW and up lands at or beyond 2.0
		if (smp_s1.power >= 16'd750) begin
			p_n = TWO_Q16;
		end else begin
			p_n = p_prod[34:17];
		end
	end

	// temperature: ceiling 65 C = 1040; zero and below read as 0
	always_comb begin
		t_pos = !smp_s1.temp[12] && (smp_s1.temp != 13'd0);
		t_u   = smp_s1.temp[11:0];
		if (t_u <= 12'd1040) begin
			t_m = {t_u, 1'b0};
		end else begin
			t_m = 13'(t_u) + 13'd1040;
		end
		t_prod = 36'(t_m) * 36'(T_RECIP);
		if (!t_pos) begin
			t_n = '0;
		end else if (t_prod[35:18] > TWO_Q16) begin
			t_n = TWO_Q16;
		end else begin
			t_n = t_prod[35:18];
		end
	end

	// error: ceiling 0.02, no division needed since 50 and 10 are integral
	always_comb begin
		e_sat = (smp_s1.err > 17'd65536) ? 17'd65536 : smp_s1.err;
		if (e_sat <= 17'd1310) begin
			e_v = 20'(e_sat) * 20'd50;
		end else begin
			e_v = 20'(e_sat) * 20'd10 + 20'd52428;
		end
		e_n = (e_v > 20'(THREE_Q16)) ? THREE_Q16 : e_v[17:0];
	end

	// exposure: ceiling 0.30; both segments brought to a common /9
	always_comb begin
		x_sat = (smp_s1.expo > 17'd65536) ? 17'd65536 : smp_s1.expo;
		if (x_sat <= 17'd19660) begin
			x_m = 21'(x_sat) * 21'd30;
		end else begin
			x_m = 21'(x_sat) * 21'd10 + 21'd393216;
		end
		x_prod = 42'(x_m) * 42'(X_RECIP);
		x_n = (x_prod[41:24] > TWO_Q16) ? TWO_Q16 : x_prod[41:24];
	end

	always_comb begin
		norm_d.p    = p_n;
		norm_d.t    = t_n;
		norm_d.e    = e_n;
		norm_d.x    = x_n;
		norm_d.last = smp_s1.last;
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			norm_s2 <= norm_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/trps_score.sv
// Score stages: weighted sum of the normalized values (stage 3) and the
// truncating divide by 400 (stage 4). Uses trps_pkg.
`default_nettype none

module trps_score (
	input  wire                     clk,
	input  trps_pkg::norm_t         norm_s2,
	input  trps_pkg::ctl_t          ctl,
	output logic [16:0]             risk_s4,
	output logic                    last_s4
);
	import trps_pkg::*;

	// floor(s / 400) = (s * S_RECIP) >> 33, exact for s < 2^24
	localparam logic [24:0] S_RECIP = 25'd21474837;

	logic [23:0] sum_d;
	logic [23:0] sum_s3;
	logic        last_s3;
	logic [48:0] div_prod;

	// 0.35/0.30/0.20/0.15 over 4, scaled to integers over 400
	always_comb begin
		sum_d = 24'(norm_s2.p) * 24'd35 + 24'(norm_s2.t) * 24'd30
			+ 24'(norm_s2.e) * 24'd20 + 24'(norm_s2.x) * 24'd15;
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			sum_s3  <= sum_d;
			last_s3 <= norm_s2.last;
		end
	end

	// quotient tops out near 0.55, so no clamp to 1.0 is needed
	assign div_prod = 49'(sum_s3) * 49'(S_RECIP);

	always_ff @(posedge clk) begin
		if (ctl.en_s4) begin
			risk_s4 <= {1'b0, div_prod[48:33]};
			last_s4 <= last_s3;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/trps_peak.sv
// Window peak tracker and output register: folds each risk into the running
// maximum and emits it on the window's last sample. Uses trps_pkg.
`default_nettype none

module trps_peak (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          valid_s4,
	input  wire  [16:0]  risk_s4,
	input  wire          last_s4,
	output logic         fire_s4,
	output logic         score_valid,
	input  wire          score_stall,
	output logic [16:0]  risk_score_q16
);
	import trps_pkg::*;

	logic [16:0] peak_q;
	logic [16:0] peak_next;
	logic        out_valid_q;
	logic [16:0] out_data_q;
	logic        out_free;

	assign out_free  = !out_valid_q || !score_stall;
	// a non-last sample never needs the output register
	assign fire_s4   = valid_s4 && (!last_s4 || out_free);
	assign peak_next = (risk_s4 > peak_q) ? risk_s4 : peak_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire_s4) begin
				peak_q <= last_s4 ? '0 : peak_next;
			end
			if (fire_s4 && last_s4) begin
				out_valid_q <= 1'b1;
			end else if (!score_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s4 && last_s4) begin
			out_data_q <= peak_next;
		end
	end

	assign score_valid    = out_valid_q;
	assign risk_score_q16 = out_data_q;

endmodule

`default_nettype wire

// File: rtl/core/telemetry_risk_peak_score.sv
// Telemetry risk peak score, top level. Takes one sample transaction per clock
// unless sample_stall holds it, and returns the peak Q16 risk of the window on
// the sample marked last. After the last sample is accepted it passes through the
// input register, normalization (one constant multiply per field), weighted sum,
// divide by 400 (one constant multiply), then the peak compare into the output
// register. Throughput is one sample per cycle while no stall holds the flow;
// each stage holds its data only while the stage after it is full, so a waiting
// score blocks the input only once the four stages fill up.
// Depends on trps_pkg, trps_norm, trps_score and trps_peak.
`default_nettype none

module telemetry_risk_peak_score (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          sample_valid,
	output logic         sample_stall,
	input  wire  [15:0]  pwr_mw,
	input  wire  [12:0]  temperature_q4,
	input  wire  [16:0]  error_q16,
	input  wire  [16:0]  exposure_q16,
	input  wire          last_sample,
	output logic         score_valid,
	input  wire          score_stall,
	output logic [16:0]  risk_score_q16
);
	import trps_pkg::*;

	sample_t     smp_s1;
	norm_t       norm_s2;
	ctl_t        ctl;
	logic [16:0] risk_s4;
	logic        last_s4;
	logic        fire_s4;

	logic        valid_s1_q;
	logic        valid_s2_q;
	logic        valid_s3_q;
	logic        valid_s4_q;
	logic        en_s1;

	// a stage loads when it is empty or its contents move on this cycle
	always_comb begin
		ctl.en_s4 = !valid_s4_q || fire_s4;
		ctl.en_s3 = !valid_s3_q || ctl.en_s4;
		ctl.en_s2 = !valid_s2_q || ctl.en_s3;
		en_s1     = !valid_s1_q || ctl.en_s2;
	end

	assign sample_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
			valid_s2_q <= 1'b0;
			valid_s3_q <= 1'b0;
			valid_s4_q <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1_q <= sample_valid;
			end
			if (ctl.en_s2) begin
				valid_s2_q <= valid_s1_q;
			end
			if (ctl.en_s3) begin
				valid_s3_q <= valid_s2_q;
			end
			if (ctl.en_s4) begin
				valid_s4_q <= valid_s3_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			smp_s1.power <= pwr_mw;
			smp_s1.temp  <= temperature_q4;
			smp_s1.err   <= error_q16;
			smp_s1.expo  <= exposure_q16;
			smp_s1.last  <= last_sample;
		end
	end

	trps_norm u_norm (
		.clk     (clk),
		.smp_s1  (smp_s1),
		.ctl     (ctl),
		.norm_s2 (norm_s2)
	);

	trps_score u_score (
		.clk     (clk),
		.norm_s2 (norm_s2),
		.ctl     (ctl),
		.risk_s4 (risk_s4),
		.last_s4 (last_s4)
	);

	trps_peak u_peak (
		.clk            (clk),
		.arst_n         (arst_n),
		.valid_s4       (valid_s4_q),
		.risk_s4        (risk_s4),
		.last_s4        (last_s4),
		.fire_s4        (fire_s4),
		.score_valid    (score_valid),
		.score_stall    (score_stall),
		.risk_score_q16 (risk_score_q16)
	);

endmodule

`default_nettype wire

// File: sim/telemetry_risk_peak_score_test.sv
// Testbench for telemetry_risk_peak_score: sample transactions with random gaps
// and random score stalls, window peaks predicted in a scoreboard class.
// Depends on trps_pkg and the telemetry_risk_peak_score RTL.

module telemetry_risk_peak_score_test;
	import trps_pkg::*;

	localparam int LIMIT_CYCLES = 1000000;
	localparam int NUM_RANDOM   = 1430;
	localparam int TAIL_CYCLES  = 20;

	class peak_score_board;
		logic [16:0] window_peak;
		logic [16:0] expected_scores[$];
		int          mismatches;

		function new();
			window_peak = '0;
			mismatches  = 0;
		endfunction

		task report_mismatch(string msg);
			$display("mismatch: %s", msg);
			mismatches++;
		endtask

		function logic [17:0] clamp_q(longint unsigned v, longint unsigned hi);
			return (v > hi) ? 18'(hi) : 18'(v);
		endfunction

		// Piecewise normalizations, all Q2.16 truncated
		function logic [17:0] norm_power(logic [15:0] raw);
			longint unsigned p, v;
			p = 64'(raw);
			if (p <= 250)
				v = (p * 65536) / 250;
			else
				v = (16384000 + p * 65536) / 500;
			return clamp_q(v, 64'(TWO_Q16));
		endfunction

		function logic [17:0] norm_temp(logic [12:0] raw);
			int t;
			longint unsigned u, v;
			t = int'($signed(raw));
			if (t <= 0)
				return '0;
			u = 64'(t);
			if (u <= 1040)
				v = (u * 4096) / 65;
			else
				v = (4259840 + u * 4096) / 130;
			return clamp_q(v, 64'(TWO_Q16));
		endfunction

		function logic [17:0] norm_error(longint unsigned e);
			longint unsigned v;
			if (e * 50 <= 65536)
				v = e * 50;
			else
				v = (e * 50 + 262144) / 5;
			return clamp_q(v, 64'(THREE_Q16));
		endfunction

		function logic [17:0] norm_exposure(longint unsigned x);
			longint unsigned v;
			if (x * 10 <= 196608)
				v = (x * 10) / 3;
			else
				v = (393216 + x * 10) / 9;
			return clamp_q(v, 64'(TWO_Q16));
		endfunction

		function logic [16:0] sample_risk(sample_t s);
			longint unsigned e, x, sum;
			e = 64'(s.err);
			x = 64'(s.expo);
			if (e > ONE_Q16)
				e = 64'(ONE_Q16);
			if (x > ONE_Q16)
				x = 64'(ONE_Q16);
			sum = 35 * longint'(norm_power(s.power)) + 30 * longint'(norm_temp(s.temp))
				+ 20 * longint'(norm_error(e)) + 15 * longint'(norm_exposure(x));
			return 17'(clamp_q(sum / 400, 64'(ONE_Q16)));
		endfunction

		function void note_sample(sample_t s);
			logic [16:0] risk;
			risk = sample_risk(s);
			if (risk > window_peak)
				window_peak = risk;
			// the last sample's own risk counts before the peak goes out
			if (s.last) begin
				expected_scores.push_back(window_peak);
				window_peak = '0;
			end
		endfunction

		task check_score(logic [16:0] score);
			logic [16:0] want;
			if (expected_scores.size() == 0) begin
				report_mismatch($sformatf("score %0d with no window closed", score));
				return;
			end
			want = expected_scores.pop_front();
			if (score !== want)
				report_mismatch($sformatf("risk_score_q16 got %0d want %0d", score, want));
		endtask

		function int pending();
			return expected_scores.size();
		endfunction
	endclass

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        sample_valid   = 1'b0;
	logic [15:0] pwr_mw         = '0;
	logic [12:0] temperature_q4 = '0;
	logic [16:0] error_q16      = '0;
	logic [16:0] exposure_q16   = '0;
	logic        last_sample    = 1'b0;
	logic        score_stall    = 1'b0;
	logic        sample_stall;
	logic        score_valid;
	logic [16:0] risk_score_q16;

	peak_score_board board = new();
	bit steady     = 1'b0;
	int stall_left = 0;
	int stall_pick;
	int cycle_count = 0;

	telemetry_risk_peak_score DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (sample_valid),
		.sample_stall   (sample_stall),
		.pwr_mw         (pwr_mw),
		.temperature_q4 (temperature_q4),
		.error_q16      (error_q16),
		.exposure_q16   (exposure_q16),
		.last_sample    (last_sample),
		.score_valid    (score_valid),
		.score_stall    (score_stall),
		.risk_score_q16 (risk_score_q16)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("FAIL telemetry_risk_peak_score");
			$finish;
		end
	end

	// Score side: stretches of ready, short stalls and a few long ones
	always @(negedge clk) begin
		if (steady) begin
			score_stall <= 1'b0;
			stall_left  <= 0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else begin
			stall_pick = $urandom_range(0, 99);
			if (stall_pick < 60) begin
				score_stall <= 1'b0;
				stall_left  <= $urandom_range(0, 7);
			end else if (stall_pick < 92) begin
				score_stall <= 1'b1;
				stall_left  <= $urandom_range(0, 2);
			end else begin
				score_stall <= 1'b1;
				stall_left  <= $urandom_range(9, 39);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && score_valid && !score_stall)
			board.check_score(risk_score_q16);
	end

	function automatic sample_t make_sample(int p, int t, int e, int x, bit last);
		sample_t s;
		s.power = 16'(p);
		s.temp  = 13'(t);
		s.err   = 17'(e);
		s.expo  = 17'(x);
		s.last  = last;
		return s;
	endfunction

	// Mostly values around the ceilings, where the slopes change
	function automatic sample_t random_sample(int last_odds);
		sample_t s;
		case ($urandom_range(0, 3))
			0: s.power = 16'($urandom_range(0, 65535));
			1: s.power = 16'($urandom_range(200, 300));
			default: s.power = 16'($urandom_range(0, 800));
		endcase
		case ($urandom_range(0, 3))
			0: s.temp = 13'($urandom_range(0, 8191));
			1: s.temp = 13'($urandom_range(980, 1100));
			default: s.temp = 13'($urandom_range(0, 3200));
		endcase
		case ($urandom_range(0, 4))
			0: s.err = 17'($urandom_range(0, 131071));
			1: s.err = 17'($urandom_range(1250, 1400));
			2: s.err = 17'd65536;
			default: s.err = 17'($urandom_range(0, 16000));
		endcase
		case ($urandom_range(0, 3))
			0: s.expo = 17'($urandom_range(0, 131071));
			1: s.expo = 17'($urandom_range(19000, 20500));
			default: s.expo = 17'($urandom_range(0, 65536));
		endcase
		s.last = ($urandom_range(0, last_odds - 1) == 0);
		return s;
	endfunction

	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Called and returns at a falling edge; valid stays up between back-to-back transactions
	task automatic send_sample(sample_t s, int gap);
		if (gap > 0) begin
			sample_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_valid   = 1'b1;
		pwr_mw         = s.power;
		temperature_q4 = s.temp;
		error_q16      = s.err;
		exposure_q16   = s.expo;
		last_sample    = s.last;
		do @(posedge clk); while (sample_stall);
		board.note_sample(s);
		@(negedge clk);
	endtask

	task automatic drain_results();
		sample_valid = 1'b0;
		while (board.pending() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		sample_t directed[$];
		int last_odds;

		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		directed.push_back(make_sample(0, 0, 0, 0, 1));
		directed.push_back(make_sample(250, 1040, 1310, 19660, 0));
		directed.push_back(make_sample(251, 1041, 1311, 19661, 1));
		directed.push_back(make_sample(65535, 4095, 65536, 65536, 1));
		// over-range error and exposure saturate to one
		directed.push_back(make_sample(65535, 4095, 131071, 131071, 1));
		directed.push_back(make_sample(0, -4096, 0, 0, 1));
		directed.push_back(make_sample(0, -1, 0, 0, 0));
		directed.push_back(make_sample(0, 1, 1, 1, 1));
		// peak early in the window, smaller samples after it
		directed.push_back(make_sample(800, 3000, 15000, 65536, 0));
		directed.push_back(make_sample(10, 10, 10, 10, 0));
		directed.push_back(make_sample(0, 0, 0, 0, 1));
		// back-to-back last samples: the second sees a cleared peak
		directed.push_back(make_sample(100, 500, 500, 5000, 1));
		directed.push_back(make_sample(0, 0, 0, 0, 1));
		directed.push_back(make_sample(750, 3120, 14418, 65536, 0));
		directed.push_back(make_sample(749, 3119, 14417, 65535, 1));
		directed.push_back(make_sample(16'hAAAA, 13'h0AAA, 17'h15555, 17'h0AAAA, 0));
		directed.push_back(make_sample(16'h5555, 13'h1555, 17'h0AAAA, 17'h15555, 1));
		directed.push_back(make_sample(0, 4095, 0, 0, 0));
		directed.push_back(make_sample(65535, 0, 0, 0, 0));
		directed.push_back(make_sample(0, 0, 65536, 0, 0));
		directed.push_back(make_sample(0, 0, 0, 65536, 1));
		directed.push_back(make_sample(1, 2, 3, 4, 1));

		steady = 1'b1;
		foreach (directed[i])
			send_sample(directed[i], 0);
		drain_results();
		steady = 1'b0;
		foreach (directed[i])
			send_sample(directed[i], pick_gap());
		drain_results();

		last_odds = 6;
		for (int n = 0; n < NUM_RANDOM; n++) begin
			if (n % 160 == 0) begin
				steady = ($urandom_range(0, 3) == 0);
				case ($urandom_range(0, 2))
					0: last_odds = 2;
					1: last_odds = 6;
					default: last_odds = 20;
				endcase
			end
			if (n % 350 == 175)
				drain_results();
			send_sample(random_sample(last_odds), pick_gap());
		end

		sample_valid = 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.mismatches == 0)
			$display("PASS telemetry_risk_peak_score");
		else
			$display("FAIL telemetry_risk_peak_score");
		$finish;
	end

endmodule
